[hw/rtl/pba_pkg.sv]
package pba_pkg;

    // Address layout: 4 KiB pages, 32 pages to a map word
    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned WORD_SHIFT = 17;
    localparam int unsigned BIT_W      = 5;
    localparam int unsigned WORD_NUM_W = ADDR_W - WORD_SHIFT;
    localparam int unsigned SUM_NUM_W  = WORD_NUM_W - BIT_W;
    localparam int unsigned COUNT_W    = 21;

    localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

    // Request codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        K_NOP,
        K_ALLOC,
        K_FREE,
        K_MARK
    } t_kind;

    // Classified command: word range for alloc, word and bit for free/mark
    typedef struct packed {
        t_kind                   kind;
        logic [WORD_NUM_W-1:0]   lo;
        logic [WORD_NUM_W-1:0]   hi;
        logic [BIT_W-1:0]        bit_sel;
    } t_cmd;

    // Index of the lowest set bit, zero when none
    function automatic logic [BIT_W-1:0] first_one(input logic [31:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = 31; b >= 0; b--) begin
            if (v[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

[hw/rtl/pba_if.sv]
// Request channel
interface pba_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [pba_pkg::ADDR_W-1:0]    page_address;
    logic [pba_pkg::ADDR_W-1:0]    range_lower;
    logic [pba_pkg::ADDR_W-1:0]    range_upper;

    modport source (output valid, output op, output page_address,
                    output range_lower, output range_upper, input ready);
    modport sink   (input valid, input op, input page_address,
                    input range_lower, input range_upper, output ready);
endinterface

// Result channel
interface pba_out_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::ADDR_W-1:0]    alloc_address;
    logic                          found;
    logic [pba_pkg::COUNT_W-1:0]   free_page_count;

    modport source (output valid, output alloc_address, output found,
                    output free_page_count, input ready);
    modport sink   (input valid, input alloc_address, input found,
                    input free_page_count, output ready);
endinterface

[hw/rtl/pba_front.sv]
module pba_front #(
    parameter int unsigned MAP_WORDS = 32768
) (
    pba_in_if.sink          i_in,
    input  logic            i_clearing,
    input  logic            i_queue_full,
    output logic            o_push,
    output pba_pkg::t_cmd   o_cmd
);

    localparam logic [pba_pkg::WORD_NUM_W-1:0] LAST_WORD =
        pba_pkg::WORD_NUM_W'(MAP_WORDS - 1);

    logic [pba_pkg::WORD_NUM_W-1:0] lo_word;
    logic [pba_pkg::WORD_NUM_W-1:0] hi_raw;
    logic [pba_pkg::WORD_NUM_W-1:0] hi_word;
    logic [pba_pkg::WORD_NUM_W-1:0] page_word;
    logic                           page_in_map;

    // Word numbers from byte addresses, upper bound clipped to the map
    assign lo_word     = i_in.range_lower[pba_pkg::ADDR_W-1:pba_pkg::WORD_SHIFT];
    assign hi_raw      = i_in.range_upper[pba_pkg::ADDR_W-1:pba_pkg::WORD_SHIFT];
    assign hi_word     = (hi_raw > LAST_WORD) ? LAST_WORD : hi_raw;
    assign page_word   = i_in.page_address[pba_pkg::ADDR_W-1:pba_pkg::WORD_SHIFT];
    assign page_in_map = (page_word <= LAST_WORD);

    // Classify: empty ranges, off-map pages and unused codes become no-ops
    always_comb begin
        o_cmd.kind    = pba_pkg::K_NOP;
        o_cmd.lo      = lo_word;
        o_cmd.hi      = hi_word;
        o_cmd.bit_sel = i_in.page_address[pba_pkg::WORD_SHIFT-1:pba_pkg::PAGE_SHIFT];
        case (i_in.op)
            pba_pkg::OP_ALLOC: begin
                if (lo_word <= hi_word) begin
                    o_cmd.kind = pba_pkg::K_ALLOC;
                end
            end
            pba_pkg::OP_FREE: begin
                o_cmd.lo = page_word;
                if (page_in_map) begin
                    o_cmd.kind = pba_pkg::K_FREE;
                end
            end
            pba_pkg::OP_MARK: begin
                o_cmd.lo = page_word;
                if (page_in_map) begin
                    o_cmd.kind = pba_pkg::K_MARK;
                end
            end
            default: begin
                o_cmd.kind = pba_pkg::K_NOP;
            end
        endcase
    end

    // Handshake: hold off while the queue is full or the map is being initialised
    assign i_in.ready = !i_queue_full && !i_clearing;
    assign o_push     = i_in.valid && i_in.ready;

endmodule

[hw/rtl/pba_queue.sv]
module pba_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pba_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output pba_pkg::t_cmd   o_cmd,
    output logic            o_empty,
    output logic            o_full
);

    pba_pkg::t_cmd                      r_slot [pba_pkg::QUEUE_DEPTH];
    logic [pba_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [pba_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [pba_pkg::QUEUE_CNT_W-1:0]    r_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == pba_pkg::QUEUE_CNT_W'(pba_pkg::QUEUE_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers wrap naturally, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from empty queue");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= pba_pkg::QUEUE_CNT_W'(pba_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond its depth");
`endif

endmodule

[hw/rtl/pba_back.sv]
module pba_back #(
    parameter int unsigned MAP_WORDS = 32768
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pba_pkg::t_cmd   i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_clearing,
    pba_out_if.source       o_out
);

    localparam int unsigned WIDX      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned SUM_WORDS = (MAP_WORDS + 31) / 32;
    localparam int unsigned SIDX      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int unsigned WN        = pba_pkg::WORD_NUM_W;
    localparam int unsigned BW        = pba_pkg::BIT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

    t_state                         r_state, n_state;
    logic [WIDX-1:0]                r_clr_idx, n_clr_idx;
    pba_pkg::t_cmd                  r_cmd, n_cmd;
    logic [pba_pkg::SUM_NUM_W-1:0]  r_sw, n_sw;
    logic [WN-1:0]                  r_w, n_w;
    logic [pba_pkg::COUNT_W-1:0]    r_count, n_count;
    logic                           r_out_valid, n_out_valid;
    logic [pba_pkg::ADDR_W-1:0]     r_out_addr, n_out_addr;
    logic                           r_out_found, n_out_found;
    logic [pba_pkg::COUNT_W-1:0]    r_out_count, n_out_count;

    // Map and summary memories (summary bit set = word has a free page)
    logic [31:0]        map_mem [MAP_WORDS];
    logic [31:0]        sum_mem [SUM_WORDS];
    logic [31:0]        r_map_q;
    logic [31:0]        r_sum_q;
    logic [WIDX-1:0]    map_raddr, map_waddr;
    logic [SIDX-1:0]    sum_raddr, sum_waddr;
    logic               map_we, sum_we;
    logic [31:0]        map_wdata, sum_wdata;

    logic               out_free;
    logic [31:0]        lo_mask, hi_mask, cand;
    logic               cand_any;
    logic [BW-1:0]      cand_b;
    logic [WN-1:0]      cand_w;
    logic [BW-1:0]      upd_b;
    logic [31:0]        upd_mask, new_word, new_sum;
    logic               old_set, flip;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        r_map_q <= map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_q <= sum_mem[sum_raddr];
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty && out_free;
    assign o_clearing = (r_state == S_CLEAR);

    // Scan: candidate summary bits within the requested word range
    assign lo_mask  = (r_sw == r_cmd.lo[WN-1:BW]) ? (pba_pkg::FULL_WORD << r_cmd.lo[BW-1:0])
                                                  : pba_pkg::FULL_WORD;
    assign hi_mask  = (r_sw == r_cmd.hi[WN-1:BW])
                    ? (pba_pkg::FULL_WORD >> (5'd31 - r_cmd.hi[BW-1:0]))
                    : pba_pkg::FULL_WORD;
    assign cand     = r_sum_q & lo_mask & hi_mask;
    assign cand_any = (cand != '0);
    assign cand_b   = pba_pkg::first_one(cand);
    assign cand_w   = {r_sw, cand_b};

    // Update: flip one bit of the fetched map word
    assign upd_b    = (r_cmd.kind == pba_pkg::K_ALLOC) ? pba_pkg::first_one(~r_map_q)
                                                       : r_cmd.bit_sel;
    assign upd_mask = 32'd1 << upd_b;
    assign old_set  = ((r_map_q & upd_mask) != '0);
    assign new_word = (r_cmd.kind == pba_pkg::K_FREE) ? (r_map_q & ~upd_mask)
                                                      : (r_map_q | upd_mask);
    assign flip     = (r_cmd.kind == pba_pkg::K_FREE) ? old_set : !old_set;

    always_comb begin
        new_sum = r_sum_q;
        new_sum[r_w[BW-1:0]] = (new_word != pba_pkg::FULL_WORD);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_cmd       = r_cmd;
        n_sw        = r_sw;
        n_w         = r_w;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_found = r_out_found;
        n_out_count = r_out_count;
        map_raddr   = r_w[WIDX-1:0];
        sum_raddr   = r_sw[SIDX-1:0];
        map_we      = 1'b0;
        map_waddr   = r_w[WIDX-1:0];
        map_wdata   = new_word;
        sum_we      = 1'b0;
        sum_waddr   = r_w[SIDX+BW-1:BW];
        sum_wdata   = new_sum;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_idx;
                map_wdata = pba_pkg::FULL_WORD;
                sum_we    = (32'(r_clr_idx) < SUM_WORDS);
                sum_waddr = r_clr_idx[SIDX-1:0];
                sum_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == WIDX'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        pba_pkg::K_ALLOC: begin
                            n_sw      = i_cmd.lo[WN-1:BW];
                            sum_raddr = i_cmd.lo[SIDX+BW-1:BW];
                            n_state   = S_SCAN;
                        end
                        pba_pkg::K_FREE, pba_pkg::K_MARK: begin
                            n_w       = i_cmd.lo;
                            map_raddr = i_cmd.lo[WIDX-1:0];
                            sum_raddr = i_cmd.lo[SIDX+BW-1:BW];
                            n_state   = S_UPD;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_addr  = '0;
                            n_out_found = 1'b0;
                            n_out_count = r_count;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (cand_any) begin
                    n_w       = cand_w;
                    map_raddr = cand_w[WIDX-1:0];
                    n_state   = S_UPD;
                end else if (r_sw == r_cmd.hi[WN-1:BW]) begin
                    // nothing free in range
                    n_out_valid = 1'b1;
                    n_out_addr  = '0;
                    n_out_found = 1'b0;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else begin
                    n_sw      = r_sw + 1'b1;
                    sum_raddr = n_sw[SIDX-1:0];
                end
            end
            S_UPD: begin
                map_we = flip;
                sum_we = flip;
                if (flip) begin
                    n_count = (r_cmd.kind == pba_pkg::K_FREE) ? (r_count + 1'b1)
                                                              : (r_count - 1'b1);
                end
                n_out_valid = 1'b1;
                n_out_found = (r_cmd.kind == pba_pkg::K_ALLOC);
                n_out_addr  = (r_cmd.kind == pba_pkg::K_ALLOC)
                            ? {r_w, upd_b, {pba_pkg::PAGE_SHIFT{1'b0}}} : '0;
                n_out_count = n_count;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and result registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_sw        <= n_sw;
        r_w         <= n_w;
        r_out_addr  <= n_out_addr;
        r_out_found <= n_out_found;
        r_out_count <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.alloc_address   = r_out_addr;
    assign o_out.found           = r_out_found;
    assign o_out.free_page_count = r_out_count;

`ifndef SYNTH
    a_alloc_word_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_cmd.kind == pba_pkg::K_ALLOC)
            |-> (r_map_q != pba_pkg::FULL_WORD))
        else $error("summary pointed at a full map word");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1 ||
                  r_count == $past(r_count) - 1'b1))
        else $error("free count moved by more than one");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_pop && !r_out_valid))
        else $error("activity during map initialisation");
`endif

endmodule

[hw/rtl/page_bitmap_allocator_top.sv]
// Page bitmap allocator: one bit per 4 KiB page (set = used), 32 pages to a
// map word, plus a 21-bit free page count returned with every result word.
// Requests are allocate-in-range (op 0), free (op 1) and mark-used (op 2);
// off-map pages and unused codes are answered without effect. After reset the
// block sets every map word to used and accepts no requests meanwhile. A
// per-word summary memory (one bit per map word, set when the word has a free
// page) drives allocation. Once dequeued a no-op is answered directly; free
// and mark-used read the map word and then update it; allocate reads summary
// words, one per cycle through the summary memory's read port, until it finds
// a map word with a free page (then reads and updates that word) or reaches
// the end of the range. Each summary word covers 32 map words (4 MiB).
// A two-entry command queue sits between the request side and the sequencer,
// and the result is held in an output register so the queue can take requests
// while it waits; the sequencer dequeues only once that register is free.
module page_bitmap_allocator_top #(
    parameter int unsigned MAP_WORDS = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pba_in_if.sink      i_in,
    pba_out_if.source   o_out
);

    pba_pkg::t_cmd  push_cmd;
    pba_pkg::t_cmd  head_cmd;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           clearing;

    // Request classification
    pba_front #(
        .MAP_WORDS (MAP_WORDS)
    ) u_front (
        .i_in         (i_in),
        .i_clearing   (clearing),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Command queue
    pba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Map sequencer and result register
    pba_back #(
        .MAP_WORDS (MAP_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );

endmodule
